// File: rtl/tod_pkg.sv
// Shared types and constants for the time-of-day clock with alarm.
package tod_pkg;

   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int COUNT_W  = 8;
   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 3;
   localparam int WDATA_W  = 8;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   // Largest value of each field before it wraps to zero
   localparam logic [HOUR_W-1:0]   HOUR_MAX   = HOUR_W'(23);
   localparam logic [MINUTE_W-1:0] MINUTE_MAX = MINUTE_W'(59);
   localparam logic [SECOND_W-1:0] SECOND_MAX = SECOND_W'(59);

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 2'd0,
      CMD_ADJUST = 2'd1,
      CMD_LOAD   = 2'd2
   } cmd_type;

   typedef enum logic [INDEX_W-1:0] {
      REG_MEASURE_PERIOD = 3'd0,
      REG_ALARM_ENABLE   = 3'd1,
      REG_ALARM_HOUR     = 3'd2,
      REG_ALARM_MINUTE   = 3'd3,
      REG_ALARM_SECOND   = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  measure_period;
      logic                alarm_enable;
      logic [HOUR_W-1:0]   alarm_hour;
      logic [MINUTE_W-1:0] alarm_minute;
      logic [SECOND_W-1:0] alarm_second;
   } cfg_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [HOUR_W-1:0]   hour_in;
      logic [MINUTE_W-1:0] minute_in;
      logic [SECOND_W-1:0] second_in;
   } req_type;

   typedef struct packed {
      logic [HOUR_W-1:0]   hour_out;
      logic [MINUTE_W-1:0] minute_out;
      logic [SECOND_W-1:0] second_out;
      logic                save_time;
      logic                measure_now;
      logic                alarm_hit;
      logic                led_state;
   } rsp_type;

endpackage

// File: rtl/time_of_day_clock_with_alarm.sv
// Top level: input register, time-keeping core and result register.
// Hours/minutes/seconds clock driven by transactions on the req_ stream
// (tuser = command: tick, adjust or load). Every request yields exactly one
// response carrying the time after it plus save_time, measure_now, alarm_hit
// and the LED bit. One request is taken per clock cycle unless backpressure
// holds the input. A request waits in the input register, and the single
// pass between the registers updates all state and loads the result register
// once the result register is free. Its response stays valid in the result
// register until it is taken with rsp_tready high. Backpressure on rsp_tready
// holds the result register and the pending request. The input side keeps
// accepting while the input register is empty or the result register is free
// or being drained. Configuration writes on the csr_ port are taken every
// cycle and belong in idle periods only.
module time_of_day_clock_with_alarm (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [4:0] hour_in, [10:5] minute_in, [16:11] second_in, [23:17] zero
   input  logic [tod_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] cmd
   input  logic [tod_pkg::CMD_W-1:0]        req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [4:0] hour_out, [10:5] minute_out, [16:11] second_out, [17] save_time,
   // [18] measure_now, [19] alarm_hit, [20] led_state, [23:21] zero
   output logic [tod_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tod_pkg::INDEX_W-1:0]      csr_index,
   input  logic [tod_pkg::WDATA_W-1:0]      csr_wdata
);
   import tod_pkg::*;

   cfg_type cfg;
   req_type req_ff, req_in;
   rsp_type rsp_ff, core_rsp;
   logic    req_valid_ff, rsp_valid_ff;
   logic    out_ready, step_en;

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign step_en    = req_valid_ff && out_ready;
   assign req_tready = !req_valid_ff || out_ready;

   assign req_in.cmd       = cmd_type'(req_tuser);
   assign req_in.hour_in   = req_tdata[HOUR_W-1:0];
   assign req_in.minute_in = req_tdata[HOUR_W+MINUTE_W-1:HOUR_W];
   assign req_in.second_in = req_tdata[HOUR_W+MINUTE_W+SECOND_W-1:HOUR_W+MINUTE_W];

   tod_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tod_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (req_ff),
      .cfg     (cfg),
      .res     (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (out_ready) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff <= req_in;
      end
      if (step_en) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.led_state, rsp_ff.alarm_hit, rsp_ff.measure_now,
                        rsp_ff.save_time, rsp_ff.second_out, rsp_ff.minute_out,
                        rsp_ff.hour_out};

endmodule

// File: rtl/tod_csr.sv
// Configuration register file for the measurement period and alarm time.
module tod_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tod_pkg::INDEX_W-1:0]   csr_index,
   input  logic [tod_pkg::WDATA_W-1:0]   csr_wdata,
   output tod_pkg::cfg_type              cfg
);
   import tod_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_MEASURE_PERIOD: cfg_in.measure_period = csr_wdata[COUNT_W-1:0];
            REG_ALARM_ENABLE:   cfg_in.alarm_enable   = csr_wdata[0];
            REG_ALARM_HOUR:     cfg_in.alarm_hour     = csr_wdata[HOUR_W-1:0];
            REG_ALARM_MINUTE:   cfg_in.alarm_minute   = csr_wdata[MINUTE_W-1:0];
            REG_ALARM_SECOND:   cfg_in.alarm_second   = csr_wdata[SECOND_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/tod_core.sv
// Time-keeping state and the per-transaction update of time, counter and flags.
module tod_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  tod_pkg::req_type  item,
   input  tod_pkg::cfg_type  cfg,
   output tod_pkg::rsp_type  res
);
   import tod_pkg::*;

   logic [HOUR_W-1:0]   hours_ff, hours_in;
   logic [MINUTE_W-1:0] minutes_ff, minutes_in;
   logic [SECOND_W-1:0] seconds_ff, seconds_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                blink_ff, blink_in;
   logic [COUNT_W-1:0]  count_inc;
   logic                sec_wrap, min_wrap;
   logic                save, meas, hit;

   assign sec_wrap  = (seconds_ff >= SECOND_MAX);
   assign min_wrap  = (minutes_ff >= MINUTE_MAX);
   assign count_inc = count_ff + COUNT_W'(1);

   always_comb begin
      hours_in   = hours_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      count_in   = count_ff;
      blink_in   = blink_ff;
      save       = 1'b0;
      meas       = 1'b0;
      hit        = 1'b0;
      case (item.cmd)
         CMD_TICK: begin
            seconds_in = sec_wrap ? '0 : seconds_ff + SECOND_W'(1);
            if (sec_wrap) begin
               save       = 1'b1;
               minutes_in = min_wrap ? '0 : minutes_ff + MINUTE_W'(1);
               if (min_wrap) begin
                  hours_in = (hours_ff >= HOUR_MAX) ? '0 : hours_ff + HOUR_W'(1);
               end
            end
            blink_in = ~blink_ff;
            // zero period keeps counting but never fires
            if (cfg.measure_period != '0 && count_inc >= cfg.measure_period) begin
               count_in = '0;
               meas     = 1'b1;
            end else begin
               count_in = count_inc;
            end
            hit = cfg.alarm_enable && hours_in == cfg.alarm_hour &&
                  minutes_in == cfg.alarm_minute && seconds_in == cfg.alarm_second;
         end
         CMD_ADJUST: begin
            if (item.hour_in != '0) begin
               hours_in = (hours_ff >= HOUR_MAX) ? '0 : hours_ff + HOUR_W'(1);
            end
            if (item.minute_in != '0) begin
               minutes_in = min_wrap ? '0 : minutes_ff + MINUTE_W'(1);
            end
            if (item.second_in != '0) begin
               seconds_in = sec_wrap ? '0 : seconds_ff + SECOND_W'(1);
            end
         end
         CMD_LOAD: begin
            hours_in   = item.hour_in;
            minutes_in = item.minute_in;
            seconds_in = item.second_in;
            count_in   = '0;
         end
         default: begin
            hours_in = hours_ff;
         end
      endcase
   end

   always_comb begin
      res.hour_out    = hours_in;
      res.minute_out  = minutes_in;
      res.second_out  = seconds_in;
      res.save_time   = save;
      res.measure_now = meas;
      res.alarm_hit   = hit;
      res.led_state   = blink_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hours_ff   <= '0;
         minutes_ff <= '0;
         seconds_ff <= '0;
         count_ff   <= '0;
         blink_ff   <= 1'b0;
      end else if (step_en) begin
         hours_ff   <= hours_in;
         minutes_ff <= minutes_in;
         seconds_ff <= seconds_in;
         count_ff   <= count_in;
         blink_ff   <= blink_in;
      end
   end

   a_load_clears_count: assert property (@(posedge clock) disable iff (reset)
      step_en && item.cmd == CMD_LOAD |=> count_ff == '0)
      else $error("measurement counter not cleared by load");

   a_tick_toggles_blink: assert property (@(posedge clock) disable iff (reset)
      step_en && item.cmd == CMD_TICK |=> blink_ff != $past(blink_ff))
      else $error("blink did not toggle on tick");

   a_flags_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      (res.save_time || res.measure_now || res.alarm_hit) |-> item.cmd == CMD_TICK)
      else $error("flag raised on a non-tick transaction");

   a_hit_needs_enable: assert property (@(posedge clock) disable iff (reset)
      res.alarm_hit |-> cfg.alarm_enable)
      else $error("alarm hit while alarm disabled");

   a_idle_holds_time: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(seconds_ff) && $stable(count_ff))
      else $error("time changed without a transaction");

endmodule
